// ===== rtl/lpd_pkg.sv =====
// Shared types and constants for the line and packet deframer.
// No dependencies.
package lpd_pkg;

  localparam int ByteWidth         = 8;
  localparam int LengthWidth       = 28;
  localparam int LenDigitBits      = 7;
  localparam int MaxLengthDigits   = 4;
  localparam int DigitCountWidth   = 3;
  localparam int FifoDepth         = 4;
  localparam int FifoPtrWidth      = $clog2(FifoDepth);
  localparam int FifoCountWidth    = $clog2(FifoDepth + 1);
  localparam int CfgIndexWidth     = 2;

  localparam logic [ByteWidth-1:0] NewlineByte  = 8'h0A;
  localparam logic [ByteWidth-1:0] ContinueMask = 8'h80;
  localparam logic [ByteWidth-1:0] DigitMask    = 8'h7F;

  typedef enum logic [2:0] {
    MODE_LINE,
    MODE_HEAD,
    MODE_LEN,
    MODE_BODY,
    MODE_CHECK
  } mode_t;

  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_BODY,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_NONE,
    STATUS_OK,
    STATUS_BAD_CHECK,
    STATUS_TOO_LONG
  } status_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_HEADER_FIRST,
    REG_HEADER_SECOND,
    REG_CHECKSUM_SEED
  } reg_index_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ByteWidth-1:0]   out_byte;
    logic                   end_of_line;
    logic [ByteWidth-1:0]   packet_id;
    logic [ByteWidth-1:0]   command;
    logic [LengthWidth-1:0] body_length;
    status_t                status;
    logic                   last;
  } result_t;

  function automatic result_t line_result(input logic [ByteWidth-1:0] value,
                                          input logic eol);
    result_t r;
    r             = '0;
    r.kind        = KIND_LINE;
    r.out_byte    = value;
    r.end_of_line = eol;
    r.status      = STATUS_NONE;
    return r;
  endfunction

endpackage

// ===== rtl/line_and_packet_deframer.sv =====
// Line and packet deframer top level: byte decode and result queue.
// Depends on lpd_pkg.
//
// Takes one byte per cycle while in_ready is high. Each byte is decoded in
// the cycle it is transferred, and its zero, one or two results go into a
// four-entry result queue that drives the output channel, so a new byte is
// taken while earlier results wait. Input ready stays high while the queue
// has two free entries; with the output side always ready the block
// sustains one byte per cycle, and a byte that releases a held start-mark
// byte plus its own result gives two results, which the queue absorbs.
module line_and_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic        end_of_line,
  output logic [7:0]  packet_id,
  output logic [7:0]  command,
  output logic [27:0] body_length,
  output logic [1:0]  status,
  output logic        last
);

  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] checksum_seed;

  lpd_pkg::mode_t mode, mode_next;
  logic        held_first_mark, held_first_mark_next;
  logic        header_count, header_count_next;
  logic [2:0]  length_digits, length_digits_next;
  logic [27:0] length_accum, length_accum_next;
  logic [27:0] body_count, body_count_next;
  logic [7:0]  running_check, running_check_next;
  logic [7:0]  current_id, current_id_next;
  logic [7:0]  current_command, current_command_next;

  logic        in_xfer;
  logic        out_xfer;
  logic        is_newline;
  logic        len_final;
  logic        len_too_long;
  logic        body_done;
  logic        start_mark;
  logic [5:0]  len_shift;
  logic [27:0] len_part;
  logic [27:0] accum_upd;
  logic [2:0]  digits_inc;
  logic [27:0] body_inc;
  logic [7:0]  check_upd;

  lpd_pkg::result_t res0, res1, lb_res, head;
  logic [1:0]  res_count;
  logic        lb_emit;

  lpd_pkg::result_t fifo_mem [lpd_pkg::FifoDepth];
  logic [lpd_pkg::FifoPtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [lpd_pkg::FifoCountWidth-1:0] fifo_count;

  assign in_ready  = fifo_count <= lpd_pkg::FifoCountWidth'(lpd_pkg::FifoDepth - 2);
  assign out_valid = fifo_count != '0;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign is_newline   = data_byte == lpd_pkg::NewlineByte;
  assign len_shift    = 6'(length_digits) * 6'(lpd_pkg::LenDigitBits);
  assign len_part     = 28'(data_byte & lpd_pkg::DigitMask) << len_shift;
  assign accum_upd    = length_accum | len_part;
  assign digits_inc   = length_digits + 3'd1;
  assign len_final    = (data_byte & lpd_pkg::ContinueMask) == '0;
  assign len_too_long = digits_inc >= 3'(lpd_pkg::MaxLengthDigits) || digits_inc == '0;
  assign body_inc     = body_count + 28'd1;
  assign body_done    = body_inc >= length_accum;
  assign check_upd    = running_check ^ data_byte;
  assign start_mark   = held_first_mark && data_byte == header_second;

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      lpd_pkg::MODE_HEAD: begin
        if (header_count) mode_next = lpd_pkg::MODE_LEN;
      end
      lpd_pkg::MODE_LEN: begin
        if (len_final) begin
          mode_next = (accum_upd == '0) ? lpd_pkg::MODE_CHECK : lpd_pkg::MODE_BODY;
        end else if (len_too_long) begin
          mode_next = lpd_pkg::MODE_LINE;
        end
      end
      lpd_pkg::MODE_BODY: begin
        if (body_done) mode_next = lpd_pkg::MODE_CHECK;
      end
      lpd_pkg::MODE_CHECK: mode_next = lpd_pkg::MODE_LINE;
      default: mode_next = start_mark ? lpd_pkg::MODE_HEAD : lpd_pkg::MODE_LINE;
    endcase
  end

  // line byte handling shared by the line-mode arm
  always_comb begin
    lb_res  = lpd_pkg::line_result(data_byte, is_newline);
    lb_emit = is_newline || data_byte != header_first;
  end

  // data state and results
  always_comb begin
    held_first_mark_next = held_first_mark;
    header_count_next    = header_count;
    length_digits_next   = length_digits;
    length_accum_next    = length_accum;
    body_count_next      = body_count;
    running_check_next   = running_check;
    current_id_next      = current_id;
    current_command_next = current_command;
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    unique case (mode)
      lpd_pkg::MODE_HEAD: begin
        if (!header_count) begin
          current_id_next   = data_byte;
          header_count_next = 1'b1;
        end else begin
          current_command_next = data_byte;
          header_count_next    = 1'b0;
          length_digits_next   = '0;
          length_accum_next    = '0;
        end
      end
      lpd_pkg::MODE_LEN: begin
        length_accum_next  = accum_upd;
        length_digits_next = digits_inc;
        if (len_final) begin
          body_count_next    = '0;
          running_check_next = checksum_seed;
          length_digits_next = '0;
        end else if (len_too_long) begin
          res0.kind            = lpd_pkg::KIND_END;
          res0.packet_id       = current_id;
          res0.command         = current_command;
          res0.body_length     = accum_upd;
          res0.status          = lpd_pkg::STATUS_TOO_LONG;
          res0.last            = 1'b1;
          res_count            = 2'd1;
          length_digits_next   = '0;
          held_first_mark_next = 1'b0;
        end
      end
      lpd_pkg::MODE_BODY: begin
        running_check_next = check_upd;
        body_count_next    = body_inc;
        res0.kind          = lpd_pkg::KIND_BODY;
        res0.out_byte      = data_byte;
        res0.packet_id     = current_id;
        res0.command       = current_command;
        res0.body_length   = length_accum;
        res0.status        = lpd_pkg::STATUS_NONE;
        res0.last          = 1'b1;
        res_count          = 2'd1;
      end
      lpd_pkg::MODE_CHECK: begin
        res0.kind            = lpd_pkg::KIND_END;
        res0.packet_id       = current_id;
        res0.command         = current_command;
        res0.body_length     = length_accum;
        res0.status          = (data_byte == running_check) ? lpd_pkg::STATUS_OK
                                                            : lpd_pkg::STATUS_BAD_CHECK;
        res0.last            = 1'b1;
        res_count            = 2'd1;
        held_first_mark_next = 1'b0;
      end
      default: begin
        if (start_mark) begin
          held_first_mark_next = 1'b0;
          header_count_next    = 1'b0;
        end else begin
          held_first_mark_next = !lb_emit;
          if (held_first_mark) begin
            res0      = lpd_pkg::line_result(header_first, 1'b0);
            res1      = lb_res;
            res1.last = 1'b1;
            res0.last = !lb_emit;
            res_count = lb_emit ? 2'd2 : 2'd1;
          end else if (lb_emit) begin
            res0      = lb_res;
            res0.last = 1'b1;
            res_count = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      checksum_seed <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lpd_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        lpd_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        lpd_pkg::REG_CHECKSUM_SEED: checksum_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= lpd_pkg::MODE_LINE;
      held_first_mark <= 1'b0;
      header_count    <= 1'b0;
      length_digits   <= '0;
      length_accum    <= '0;
      body_count      <= '0;
      running_check   <= '0;
      current_id      <= '0;
      current_command <= '0;
    end else if (in_xfer) begin
      mode            <= mode_next;
      held_first_mark <= held_first_mark_next;
      header_count    <= header_count_next;
      length_digits   <= length_digits_next;
      length_accum    <= length_accum_next;
      body_count      <= body_count_next;
      running_check   <= running_check_next;
      current_id      <= current_id_next;
      current_command <= current_command_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_xfer && res_count != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (in_xfer && res_count == 2'd2) begin
      fifo_mem[wr_ptr + lpd_pkg::FifoPtrWidth'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (in_xfer) wr_ptr <= wr_ptr + lpd_pkg::FifoPtrWidth'(res_count);
      if (out_xfer) rd_ptr <= rd_ptr + lpd_pkg::FifoPtrWidth'(1);
      fifo_count <= fifo_count
                    + (in_xfer ? lpd_pkg::FifoCountWidth'(res_count) : '0)
                    - (out_xfer ? lpd_pkg::FifoCountWidth'(1) : '0);
    end
  end

  assign head        = fifo_mem[rd_ptr];
  assign kind        = head.kind;
  assign out_byte    = head.out_byte;
  assign end_of_line = head.end_of_line;
  assign packet_id   = head.packet_id;
  assign command     = head.command;
  assign body_length = head.body_length;
  assign status      = head.status;
  assign last        = head.last;

endmodule
